@@ hw/rtl/qbt_pkg.sv @@
package qbt_pkg;

  localparam int KEY_W      = 6;
  localparam int SLOT_W     = 6;
  localparam int IDX_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int RESULT_CAP = 64;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_KEY_OOR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_QUAD    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic cap_add;
    logic cap_flush;
    logic add_done;
    logic emit_empty;
    logic key_rd;
    logic cnt_rd;
    logic slot_rd;
    logic emit_quad;
  } qbt_ctl_t;

  typedef struct packed {
    logic empty;
    logic out_free;
    logic batch_end;
    logic last_quad;
  } qbt_sts_t;

endpackage

@@ hw/rtl/qbt_ctrl.sv @@
module qbt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             cmd_i,
  input  qbt_pkg::qbt_sts_t sts_i,
  output logic             s_ready_o,
  output qbt_pkg::qbt_ctl_t ctl_o
);
  import qbt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_EMPTY = 3'd2;
  localparam logic [2:0] S_KRD   = 3'd3;
  localparam logic [2:0] S_CRD   = 3'd4;
  localparam logic [2:0] S_SRD   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          if (cmd_i == CMD_ADD) begin
            ctl_o.cap_add = 1'b1;
            state_d       = S_ADD;
          end else begin
            ctl_o.cap_flush = 1'b1;
            state_d         = sts_i.empty ? S_EMPTY : S_KRD;
          end
        end
      end
      S_ADD: begin
        if (sts_i.out_free) begin
          ctl_o.add_done = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          ctl_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_KRD: begin
        ctl_o.key_rd = 1'b1;
        state_d      = S_CRD;
      end
      S_CRD: begin
        ctl_o.cnt_rd = 1'b1;
        state_d      = S_SRD;
      end
      S_SRD: begin
        ctl_o.slot_rd = 1'b1;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit_quad = 1'b1;
          if (sts_i.last_quad) begin
            state_d = S_IDLE;
          end else if (sts_i.batch_end) begin
            state_d = S_KRD;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/qbt_datapath.sv @@
module qbt_datapath #(
  parameter int QCAP = 64,
  parameter int KEYS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qbt_pkg::qbt_ctl_t                 ctl_i,
  input  logic [qbt_pkg::KEY_W-1:0]         key_i,
  input  logic                              m_ready_i,
  output qbt_pkg::qbt_sts_t                 sts_o,
  output logic                              m_valid_o,
  output logic [qbt_pkg::STATUS_W-1:0]      status_o,
  output logic [qbt_pkg::KEY_W-1:0]         batch_key_o,
  output logic [qbt_pkg::SLOT_W-1:0]        quad_slot_o,
  output logic [qbt_pkg::IDX_W-1:0]         idx_a_o,
  output logic [qbt_pkg::IDX_W-1:0]         idx_b_o,
  output logic [qbt_pkg::IDX_W-1:0]         idx_c_o,
  output logic [qbt_pkg::IDX_W-1:0]         idx_d_o,
  output logic [qbt_pkg::IDX_W-1:0]         idx_e_o,
  output logic [qbt_pkg::IDX_W-1:0]         idx_f_o,
  output logic                              batch_end_o,
  output logic                              last_o
);
  import qbt_pkg::*;

  localparam int QIW = (QCAP > 1) ? $clog2(QCAP) : 1;
  localparam int CW  = $clog2(QCAP + 1);
  localparam int KIW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [KEY_W:0] KEYS_V = (KEY_W + 1)'(KEYS);
  localparam logic [CW-1:0]  QCAP_V = CW'(QCAP);

  logic [CW-1:0]   cnt_mem  [KEYS];
  logic [KIW-1:0]  kord_mem [QCAP];
  logic [QIW-1:0]  slot_mem [KEYS * (2 ** QIW)];

  logic [CW-1:0]   next_slot_q;
  logic [CW-1:0]   distinct_q;
  logic [KEYS-1:0] kvalid_q;
  logic [KEY_W-1:0] key_q;
  logic            kv_q;
  logic [QIW-1:0]  k_q;
  logic [CW-1:0]   i_q;
  logic [CW-1:0]   n_q;
  logic [CW-1:0]   cnt_rd_q;
  logic [KIW-1:0]  kord_rd_q;
  logic [QIW-1:0]  slot_rd_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_idx_en_q;
  logic                out_bend_q;
  logic                out_last_q;

  logic           key_oor;
  logic           full;
  logic           add_ok;
  logic [CW-1:0]  cnt_cur;
  logic [KIW-1:0] key_in_idx;
  logic [KIW-1:0] key_q_idx;
  logic           clear_frame;
  logic           load;

  assign key_in_idx  = key_i[KIW-1:0];
  assign key_q_idx   = key_q[KIW-1:0];
  assign key_oor     = ({1'b0, key_q} >= KEYS_V);
  assign full        = (next_slot_q == QCAP_V);
  assign add_ok      = ctl_i.add_done && !key_oor && !full;
  assign cnt_cur     = kv_q ? cnt_rd_q : '0;
  assign clear_frame = ctl_i.emit_empty || (ctl_i.emit_quad && sts_o.last_quad);
  assign load        = ctl_i.add_done || ctl_i.emit_empty || ctl_i.emit_quad;

  assign sts_o.empty     = (next_slot_q == '0);
  assign sts_o.out_free  = !out_valid_q || m_ready_i;
  assign sts_o.batch_end = ((i_q + CW'(1)) == cnt_rd_q);
  assign sts_o.last_quad = ((n_q + CW'(1)) == next_slot_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_add) begin
      cnt_rd_q <= cnt_mem[key_in_idx];
    end else if (ctl_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[kord_rd_q];
    end
    if (add_ok) begin
      cnt_mem[key_q_idx] <= cnt_cur + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.key_rd) begin
      kord_rd_q <= kord_mem[k_q];
    end
    if (add_ok && (cnt_cur == '0)) begin
      kord_mem[distinct_q[QIW-1:0]] <= key_q_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.slot_rd) begin
      slot_rd_q <= slot_mem[{kord_rd_q, i_q[QIW-1:0]}];
    end
    if (add_ok) begin
      slot_mem[{key_q_idx, cnt_cur[QIW-1:0]}] <= next_slot_q[QIW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_add) begin
      key_q <= key_i;
      kv_q  <= kvalid_q[key_in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
      distinct_q  <= '0;
      kvalid_q    <= '0;
      k_q         <= '0;
      i_q         <= '0;
      n_q         <= '0;
    end else begin
      if (clear_frame) begin
        next_slot_q <= '0;
        distinct_q  <= '0;
        kvalid_q    <= '0;
      end else if (add_ok) begin
        next_slot_q           <= next_slot_q + CW'(1);
        kvalid_q[key_q_idx]   <= 1'b1;
        if (cnt_cur == '0) begin
          distinct_q <= distinct_q + CW'(1);
        end
      end
      if (ctl_i.cap_flush) begin
        k_q <= '0;
        n_q <= '0;
      end else if (ctl_i.cnt_rd) begin
        i_q <= '0;
      end else if (ctl_i.emit_quad) begin
        n_q <= n_q + CW'(1);
        i_q <= i_q + CW'(1);
        if (sts_o.batch_end) begin
          k_q <= k_q + QIW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.add_done) begin
      if (key_oor) begin
        out_status_q <= ST_KEY_OOR;
      end else if (full) begin
        out_status_q <= ST_FULL;
      end else begin
        out_status_q <= ST_ADDED;
      end
      out_key_q    <= key_q;
      out_slot_q   <= add_ok ? SLOT_W'(next_slot_q) : '0;
      out_idx_en_q <= 1'b0;
      out_bend_q   <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (ctl_i.emit_empty) begin
      out_status_q <= ST_EMPTY;
      out_key_q    <= '0;
      out_slot_q   <= '0;
      out_idx_en_q <= 1'b0;
      out_bend_q   <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (ctl_i.emit_quad) begin
      out_status_q <= ST_QUAD;
      out_key_q    <= KEY_W'(kord_rd_q);
      out_slot_q   <= SLOT_W'(slot_rd_q);
      out_idx_en_q <= 1'b1;
      out_bend_q   <= sts_o.batch_end;
      out_last_q   <= sts_o.last_quad;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign status_o    = out_status_q;
  assign batch_key_o = out_key_q;
  assign quad_slot_o = out_slot_q;
  assign batch_end_o = out_bend_q;
  assign last_o      = out_last_q;
  assign idx_a_o     = out_idx_en_q ? {out_slot_q, 2'b00} : '0;
  assign idx_b_o     = out_idx_en_q ? {out_slot_q, 2'b10} : '0;
  assign idx_c_o     = out_idx_en_q ? {out_slot_q, 2'b01} : '0;
  assign idx_d_o     = out_idx_en_q ? {out_slot_q, 2'b01} : '0;
  assign idx_e_o     = out_idx_en_q ? {out_slot_q, 2'b10} : '0;
  assign idx_f_o     = out_idx_en_q ? {out_slot_q, 2'b11} : '0;

endmodule

@@ hw/rtl/quad_batch_by_texture.sv @@
// Channel   Direction  tdata                                  tuser               tlast
// s_axis    in         texture_key [5:0]                      cmd [0]             -
// m_axis    out        batch_key, quad_slot, idx_a .. idx_f   status, batch_end   last
//
// An add is accepted with a registered read of the key's count, then updates the count,
// key list and slot list memories.
// An empty flush is accepted, then gives the single result. Any other flush is accepted,
// then for each distinct key reads the key list and count memories, and for each quad reads
// the slot list memory and emits the quad, through registered reads of these memories.
// Reset clears the frame at once through per-key valid bits; there is no clearing pass.
// A stalled output holds the block in place until the result transaction completes.
module quad_batch_by_texture #(
  parameter int MAX_QUADS = 64,
  parameter int NUM_KEYS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // texture_key [5:0], zero fill [7:6]
  input  logic [0:0]  s_axis_tuser,   // cmd [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // batch_key [5:0], quad_slot [11:6], idx_a [19:12],
                                      // idx_b [27:20], idx_c [35:28], idx_d [43:36],
                                      // idx_e [51:44], idx_f [59:52], zero fill [63:60]
  output logic [3:0]  m_axis_tuser,   // status [2:0], batch_end [3]
  output logic        m_axis_tlast    // last
);
  import qbt_pkg::*;

  localparam int QCAP = (MAX_QUADS < RESULT_CAP) ? MAX_QUADS : RESULT_CAP;
  localparam int KEYS = (NUM_KEYS < (2 ** KEY_W)) ? NUM_KEYS : (2 ** KEY_W);

  qbt_ctl_t ctl;
  qbt_sts_t sts;

  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    batch_key;
  logic [SLOT_W-1:0]   quad_slot;
  logic [IDX_W-1:0]    idx_a, idx_b, idx_c, idx_d, idx_e, idx_f;
  logic                batch_end;
  logic                last;

  qbt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .cmd_i     (s_axis_tuser[0]),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .ctl_o     (ctl)
  );

  qbt_datapath #(
    .QCAP (QCAP),
    .KEYS (KEYS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .key_i       (s_axis_tdata[KEY_W-1:0]),
    .m_ready_i   (m_axis_tready),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid),
    .status_o    (status),
    .batch_key_o (batch_key),
    .quad_slot_o (quad_slot),
    .idx_a_o     (idx_a),
    .idx_b_o     (idx_b),
    .idx_c_o     (idx_c),
    .idx_d_o     (idx_d),
    .idx_e_o     (idx_e),
    .idx_f_o     (idx_f),
    .batch_end_o (batch_end),
    .last_o      (last)
  );

  assign m_axis_tdata = {4'b0000, idx_f, idx_e, idx_d, idx_c, idx_b, idx_a,
                         quad_slot, batch_key};
  assign m_axis_tuser = {batch_end, status};
  assign m_axis_tlast = last;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input accepted while a transaction was still in progress.");

  a_single_result_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:0] != ST_QUAD) |-> m_axis_tlast)
    else $error("Non-quad result without last set.");

  a_last_quad_ends_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:0] == ST_QUAD) && m_axis_tlast |-> m_axis_tuser[3])
    else $error("Final quad of a flush does not close its batch.");

  a_no_indices_off_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:0] != ST_QUAD)
      |-> (m_axis_tdata[59:12] == '0) && !m_axis_tuser[3])
    else $error("Indices or batch end set on a result that is not a quad.");
`endif

endmodule

@@ tb/sv/tb_quad_batch_by_texture.sv @@
`timescale 1ns / 100ps

module tb_quad_batch_by_texture;
  import qbt_pkg::*;

  localparam int QUEUE_CAP  = 64;
  localparam int KEY_SPACE  = 64;
  localparam int TAIL_WAIT  = 20;
  localparam int ITEM_GOAL  = 230;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    batch_key;
    logic [SLOT_W-1:0]   quad_slot;
    logic [IDX_W-1:0]    idx_a;
    logic [IDX_W-1:0]    idx_b;
    logic [IDX_W-1:0]    idx_c;
    logic [IDX_W-1:0]    idx_d;
    logic [IDX_W-1:0]    idx_e;
    logic [IDX_W-1:0]    idx_f;
    logic                batch_end;
    logic                last;
  } quad_res_t;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic             typed;
    quad_res_t        res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned       frame_slots = 0;
  int unsigned       frame_keys = 0;
  logic [KEY_W-1:0]  key_order [QUEUE_CAP];
  int unsigned       key_quads [KEY_SPACE] = '{default: 0};
  logic [SLOT_W-1:0] key_slots [KEY_SPACE][QUEUE_CAP];

  quad_res_t batch_out[$];
  quad_res_t due_results[$];

  int errors = 0;
  int items_sent = 0;
  int tx_max = 10;
  int rx_max = 10;
  int seen_added = 0;
  int seen_full = 0;
  int seen_quads = 0;
  int seen_empty = 0;

  stim_row_t dir_rows [17];

  quad_batch_by_texture u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic quad_res_t added(input logic [KEY_W-1:0] key,
                                      input logic [SLOT_W-1:0] slot);
    quad_res_t r;
    r = '0;
    r.status = ST_ADDED;
    r.batch_key = key;
    r.quad_slot = slot;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic quad_res_t empty_flush();
    quad_res_t r;
    r = '0;
    r.status = ST_EMPTY;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void batch_quads(input logic cmd, input logic [KEY_W-1:0] key);
    quad_res_t   r;
    logic [7:0]  base;
    int unsigned done;
    int unsigned kk;
    batch_out.delete();
    r = '0;
    r.last = 1'b1;
    if (cmd == CMD_ADD) begin
      r.batch_key = key;
      if (int'(key) >= KEY_SPACE) begin
        r.status = ST_KEY_OOR;
      end else if (frame_slots >= QUEUE_CAP) begin
        r.status = ST_FULL;
      end else begin
        if (key_quads[key] == 0) begin
          key_order[frame_keys] = key;
          frame_keys++;
        end
        key_slots[key][key_quads[key]] = frame_slots[SLOT_W-1:0];
        key_quads[key]++;
        r.status = ST_ADDED;
        r.quad_slot = frame_slots[SLOT_W-1:0];
        frame_slots++;
      end
      batch_out = {batch_out, r};
    end else begin
      if (frame_slots == 0) begin
        r.status = ST_EMPTY;
        batch_out = {batch_out, r};
      end else begin
        done = 0;
        for (int k = 0; k < frame_keys; k++) begin
          kk = key_order[k];
          for (int i = 0; i < key_quads[kk]; i++) begin
            done++;
            base = {key_slots[kk][i], 2'b00};
            r.status = ST_QUAD;
            r.batch_key = kk[KEY_W-1:0];
            r.quad_slot = key_slots[kk][i];
            r.idx_a = base;
            r.idx_b = base + 8'd2;
            r.idx_c = base + 8'd1;
            r.idx_d = base + 8'd1;
            r.idx_e = base + 8'd2;
            r.idx_f = base + 8'd3;
            r.batch_end = (i + 1 == key_quads[kk]);
            r.last = (done == frame_slots);
            batch_out = {batch_out, r};
          end
        end
      end
      key_quads = '{default: 0};
      frame_keys = 0;
      frame_slots = 0;
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic typed, input quad_res_t typed_res);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, key};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    batch_quads(cmd, key);
    if (typed) begin
      due_results = {due_results, typed_res};
    end else begin
      due_results = {due_results, batch_out};
    end
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  initial begin
    quad_res_t exp_r;
    quad_res_t act_r;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      act_r.batch_key = m_axis_tdata[5:0];
      act_r.quad_slot = m_axis_tdata[11:6];
      act_r.idx_a = m_axis_tdata[19:12];
      act_r.idx_b = m_axis_tdata[27:20];
      act_r.idx_c = m_axis_tdata[35:28];
      act_r.idx_d = m_axis_tdata[43:36];
      act_r.idx_e = m_axis_tdata[51:44];
      act_r.idx_f = m_axis_tdata[59:52];
      act_r.status = m_axis_tuser[2:0];
      act_r.batch_end = m_axis_tuser[3];
      act_r.last = m_axis_tlast;
      case (act_r.status)
        ST_ADDED: seen_added++;
        ST_FULL:  seen_full++;
        ST_QUAD:  seen_quads++;
        ST_EMPTY: seen_empty++;
        default: ;
      endcase
      if (due_results.size() == 0) begin
        $error("result transaction with no expected result waiting");
        errors++;
      end else begin
        exp_r = due_results.pop_front();
        check_field("status", exp_r.status, act_r.status);
        check_field("batch_key", exp_r.batch_key, act_r.batch_key);
        check_field("quad_slot", exp_r.quad_slot, act_r.quad_slot);
        check_field("idx_a", exp_r.idx_a, act_r.idx_a);
        check_field("idx_b", exp_r.idx_b, act_r.idx_b);
        check_field("idx_c", exp_r.idx_c, act_r.idx_c);
        check_field("idx_d", exp_r.idx_d, act_r.idx_d);
        check_field("idx_e", exp_r.idx_e, act_r.idx_e);
        check_field("idx_f", exp_r.idx_f, act_r.idx_f);
        check_field("batch_end", exp_r.batch_end, act_r.batch_end);
        check_field("last", exp_r.last, act_r.last);
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] pick;
    int n_adds;
    int frame;
    int fill_waits;

    dir_rows = '{
      '{CMD_FLUSH, 6'd0,  1'b1, empty_flush()},
      '{CMD_ADD,   6'd0,  1'b1, added(6'd0, 6'd0)},
      '{CMD_ADD,   6'd63, 1'b1, added(6'd63, 6'd1)},
      '{CMD_ADD,   6'd0,  1'b1, added(6'd0, 6'd2)},
      '{CMD_ADD,   6'd42, 1'b0, quad_res_t'('0)},
      '{CMD_ADD,   6'd21, 1'b0, quad_res_t'('0)},
      '{CMD_ADD,   6'd63, 1'b0, quad_res_t'('0)},
      '{CMD_FLUSH, 6'd0,  1'b0, quad_res_t'('0)},
      '{CMD_FLUSH, 6'd63, 1'b1, empty_flush()},
      '{CMD_ADD,   6'd5,  1'b1, added(6'd5, 6'd0)},
      '{CMD_FLUSH, 6'd21, 1'b0, quad_res_t'('0)},
      '{CMD_ADD,   6'd1,  1'b0, quad_res_t'('0)},
      '{CMD_ADD,   6'd1,  1'b0, quad_res_t'('0)},
      '{CMD_ADD,   6'd1,  1'b0, quad_res_t'('0)},
      '{CMD_ADD,   6'd42, 1'b0, quad_res_t'('0)},
      '{CMD_FLUSH, 6'd42, 1'b0, quad_res_t'('0)},
      '{CMD_FLUSH, 6'd0,  1'b1, empty_flush()}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);
    end
    drain_results();

    // Well-formed frames of adds closed by a flush; two frames overrun the queue.
    frame = 0;
    fill_waits = 0;
    while (items_sent < ITEM_GOAL) begin
      if (frame > 0 && $urandom_range(0, 4) == 0) begin
        drain_results();
        fill_waits++;
      end
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      key_pool.delete();
      if (frame == 1) begin
        n_adds = $urandom_range(65, 70);
        repeat ($urandom_range(1, 8)) key_pool = {key_pool, KEY_W'($urandom_range(0, 63))};
      end else if (frame == 6) begin
        n_adds = $urandom_range(65, 68);
        key_pool = {key_pool, KEY_W'($urandom_range(0, 63))};
      end else begin
        n_adds = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        repeat ($urandom_range(1, 6)) key_pool = {key_pool, KEY_W'($urandom_range(0, 63))};
      end
      repeat (n_adds) begin
        if ($urandom_range(0, 7) == 0) begin
          pick = KEY_W'($urandom_range(0, 63));
        end else begin
          pick = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        send_item(CMD_ADD, pick, 1'b0, '0);
      end
      send_item(CMD_FLUSH, KEY_W'($urandom_range(0, 63)), 1'b0, '0);
      if ($urandom_range(0, 5) == 0) begin
        send_item(CMD_FLUSH, KEY_W'($urandom_range(0, 63)), 1'b0, '0);
      end
      frame++;
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Covered %0d input items over %0d random frames, %0d waits for an empty queue.",
             items_sent, frame, fill_waits);
    $display("Results: %0d adds, %0d dropped on a full queue, %0d quads, %0d empty flushes.",
             seen_added, seen_full, seen_quads, seen_empty);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
